@@ design/i2cms_pkg.sv @@
`timescale 1ns / 1ps
// i2cms_pkg: item types and controller status codes for the I2C master sequencer.
// No dependencies; used by the interfaces, the step logic and the top level.
package i2cms_pkg;

    localparam int unsigned MAX_SEND_DEPTH = 8;

    localparam logic [7:0] ST_START_SENT     = 8'h08;
    localparam logic [7:0] ST_RESTART_SENT   = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK      = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK     = 8'h20;
    localparam logic [7:0] ST_DATA_TX_ACK    = 8'h28;
    localparam logic [7:0] ST_DATA_TX_NACK   = 8'h30;
    localparam logic [7:0] ST_SLA_R_ACK      = 8'h40;
    localparam logic [7:0] ST_DATA_RX_ACK    = 8'h50;
    localparam logic [7:0] ST_DATA_RX_NACK   = 8'h58;

    localparam logic       RW_READ           = 1'b1;
    localparam logic       RW_WRITE          = 1'b0;
    localparam logic       ACT_START         = 1'b0;

    typedef struct packed {
        logic        action;
        logic [6:0]  device_address;
        logic        mode;
        logic [2:0]  send_count;
        logic [31:0] write_data;
        logic [2:0]  recv_count;
        logic [7:0]  status_code;
        logic [7:0]  rx_byte;
        logic        timeout;
    } t_in_item;

    typedef struct packed {
        logic        write_control;
        logic        set_start;
        logic        set_stop;
        logic        set_ack;
        logic        load_data;
        logic [7:0]  data_byte;
        logic        done_res;
        logic [15:0] read_word;
    } t_out_item;

endpackage

@@ design/i2cms_if.sv @@
`timescale 1ns / 1ps
// i2cms_in_if / i2cms_out_if: valid/ready channels for input and result items.
// Depends on i2cms_pkg for the payload types.
interface i2cms_in_if;
    logic                 valid;
    logic                 ready;
    i2cms_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface i2cms_out_if;
    logic                 valid;
    logic                 ready;
    i2cms_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/i2cms_step.sv @@
`timescale 1ns / 1ps
// i2cms_step: transaction state registers and the per-item status decode.
// Depends on i2cms_pkg. The result is combinational; state advances on i_fire.
module i2cms_step #(
    parameter int unsigned SEND_DEPTH    = 4,
    parameter int unsigned RECEIVE_DEPTH = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  i2cms_pkg::t_in_item  i_item,
    output i2cms_pkg::t_out_item o_result
);

    logic [6:0] r_slave_address, n_slave_address;
    logic       r_read_mode, n_read_mode;
    logic [2:0] r_bytes_to_send, n_bytes_to_send;
    logic [2:0] r_bytes_to_read, n_bytes_to_read;
    logic [2:0] r_send_index, n_send_index;
    logic [2:0] r_receive_index, n_receive_index;
    logic [7:0] r_send_buffer [SEND_DEPTH];
    logic [7:0] n_send_buffer [SEND_DEPTH];
    logic [7:0] r_receive_buffer [RECEIVE_DEPTH];
    logic [7:0] n_receive_buffer [RECEIVE_DEPTH];

    logic [8*i2cms_pkg::MAX_SEND_DEPTH-1:0] wide_data;
    logic [7:0] send_byte;
    logic       take_send;
    logic       store_rx;
    i2cms_pkg::t_out_item res;

    assign wide_data = {i_item.write_data, 32'b0};

    // byte at the send pointer; zero past the buffer
    always_comb begin
        send_byte = '0;
        for (int i = 0; i < SEND_DEPTH; i++) begin
            if (r_send_index == 3'(i)) begin
                send_byte = r_send_buffer[i];
            end
        end
    end

    always_comb begin
        n_slave_address = r_slave_address;
        n_read_mode     = r_read_mode;
        n_bytes_to_send = r_bytes_to_send;
        n_bytes_to_read = r_bytes_to_read;
        n_send_index    = r_send_index;
        n_receive_index = r_receive_index;
        n_send_buffer   = r_send_buffer;
        take_send       = 1'b0;
        store_rx        = 1'b0;
        res             = '0;

        if (i_item.action == i2cms_pkg::ACT_START) begin
            n_slave_address = i_item.device_address;
            n_read_mode     = i_item.mode;
            if ({1'b0, i_item.send_count} > 4'(SEND_DEPTH)) begin
                n_bytes_to_send = 3'(SEND_DEPTH);
            end else begin
                n_bytes_to_send = i_item.send_count;
            end
            n_bytes_to_read = i_item.recv_count;
            for (int i = 0; i < SEND_DEPTH; i++) begin
                n_send_buffer[i] = wide_data[8*i2cms_pkg::MAX_SEND_DEPTH-1-8*i -: 8];
            end
            n_send_index      = '0;
            n_receive_index   = '0;
            res.write_control = 1'b1;
            res.set_start     = 1'b1;
        end else if (!i_item.timeout) begin
            case (i_item.status_code)
                i2cms_pkg::ST_START_SENT: begin
                    res.write_control = 1'b1;
                    res.load_data     = 1'b1;
                    res.data_byte     = {r_slave_address, i2cms_pkg::RW_WRITE};
                end
                i2cms_pkg::ST_SLA_W_ACK: begin
                    res.write_control = 1'b1;
                    if (r_bytes_to_send == '0) begin
                        res.set_start = 1'b1;
                    end else begin
                        take_send = 1'b1;
                    end
                end
                i2cms_pkg::ST_DATA_TX_ACK: begin
                    res.write_control = 1'b1;
                    if (r_send_index != r_bytes_to_send) begin
                        take_send = 1'b1;
                    end else if (r_read_mode) begin
                        res.set_start = 1'b1;
                    end else begin
                        res.set_stop = 1'b1;
                        res.done_res = 1'b1;
                    end
                end
                i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_TX_NACK: begin
                    res.write_control = 1'b1;
                    res.set_stop      = 1'b1;
                    res.done_res      = 1'b1;
                end
                i2cms_pkg::ST_RESTART_SENT: begin
                    res.done_res = 1'b1;
                    if (r_read_mode) begin
                        res.done_res      = 1'b0;
                        res.write_control = 1'b1;
                        res.load_data     = 1'b1;
                        res.data_byte     = {r_slave_address, i2cms_pkg::RW_READ};
                    end
                end
                i2cms_pkg::ST_SLA_R_ACK: begin
                    res.done_res = 1'b1;
                    if (r_read_mode) begin
                        res.done_res      = 1'b0;
                        res.write_control = 1'b1;
                        res.set_ack       = 1'b1;
                    end
                end
                i2cms_pkg::ST_DATA_RX_ACK: begin
                    res.done_res = 1'b1;
                    if (r_read_mode) begin
                        res.done_res      = 1'b0;
                        res.write_control = 1'b1;
                        if (r_receive_index != r_bytes_to_read) begin
                            store_rx    = 1'b1;
                            res.set_ack = 1'b1;
                        end
                    end
                end
                i2cms_pkg::ST_DATA_RX_NACK: begin
                    res.done_res = 1'b1;
                    if (r_read_mode) begin
                        store_rx          = 1'b1;
                        res.write_control = 1'b1;
                        res.set_stop      = 1'b1;
                    end
                end
                default: begin
                    res.done_res = 1'b1;
                    if (r_read_mode) begin
                        res.write_control = 1'b1;
                        res.set_stop      = 1'b1;
                    end
                end
            endcase
        end

        if (take_send) begin
            res.load_data = 1'b1;
            res.data_byte = send_byte;
            n_send_index  = r_send_index + 3'd1;
        end
        if (store_rx) begin
            n_receive_index = r_receive_index + 3'd1;
        end
    end

    // received byte lands only below the buffer depth
    always_comb begin
        n_receive_buffer = r_receive_buffer;
        for (int i = 0; i < RECEIVE_DEPTH; i++) begin
            if (store_rx && r_receive_index == 3'(i)) begin
                n_receive_buffer[i] = i_item.rx_byte;
            end
        end
    end

    always_comb begin
        o_result           = res;
        o_result.read_word = {n_receive_buffer[0], n_receive_buffer[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= '0;
            r_read_mode     <= 1'b0;
            r_bytes_to_send <= '0;
            r_bytes_to_read <= '0;
            r_send_index    <= '0;
            r_receive_index <= '0;
            for (int i = 0; i < RECEIVE_DEPTH; i++) begin
                r_receive_buffer[i] <= '0;
            end
        end else if (i_fire) begin
            r_slave_address  <= n_slave_address;
            r_read_mode      <= n_read_mode;
            r_bytes_to_send  <= n_bytes_to_send;
            r_bytes_to_read  <= n_bytes_to_read;
            r_send_index     <= n_send_index;
            r_receive_index  <= n_receive_index;
            r_receive_buffer <= n_receive_buffer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_send_buffer <= n_send_buffer;
        end
    end

endmodule

@@ design/i2c_master_transaction_sequencer_top.sv @@
`timescale 1ns / 1ps
// I2C master transaction sequencer, top level. Depends on i2cms_pkg, i2cms_if, i2cms_step.
// The result of an item is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one item per cycle while no skid entry is held; a two-entry result buffer (output + skid)
// keeps an item accepted while the output stalls, and input ready drops while the skid entry is held.
// Reset (synchronous, active low) clears the transaction state, receive buffer and buffer flags.
module i2c_master_transaction_sequencer_top #(
    parameter int unsigned SEND_DEPTH    = 4,
    parameter int unsigned RECEIVE_DEPTH = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cms_in_if.sink           i_in,
    i2cms_out_if.source        o_out
);

    logic                 accept;
    logic                 out_xfer;
    i2cms_pkg::t_out_item step_result;

    logic                 r_out_valid, n_out_valid;
    logic                 r_skid_valid, n_skid_valid;
    i2cms_pkg::t_out_item r_out_item, n_out_item;
    i2cms_pkg::t_out_item r_skid_item, n_skid_item;

    assign i_in.ready = !r_skid_valid;
    assign accept     = i_in.valid && i_in.ready;
    assign out_xfer   = r_out_valid && o_out.ready;

    i2cms_step #(
        .SEND_DEPTH    (SEND_DEPTH),
        .RECEIVE_DEPTH (RECEIVE_DEPTH)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (accept),
        .i_item   (i_in.payload),
        .o_result (step_result)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        n_skid_valid = r_skid_valid;
        n_skid_item  = r_skid_item;
        if (!r_out_valid || out_xfer) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_item   = r_skid_item;
                n_skid_valid = accept;
                n_skid_item  = step_result;
            end else begin
                n_out_valid = accept;
                n_out_item  = step_result;
            end
        end else if (accept) begin
            n_skid_valid = 1'b1;
            n_skid_item  = step_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_skid_item <= n_skid_item;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready && accept) |=> r_skid_valid)
        else $error("item accepted during stall was not kept");

    a_done_no_dangling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.done_res) |->
            (r_out_item.set_stop || !r_out_item.write_control))
        else $error("done without stop while control is written");

    a_idle_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.load_data) |-> (r_out_item.data_byte == 8'h00))
        else $error("data byte set without load");
`endif

endmodule

@@ dv/i2cms_checker.sv @@
`timescale 1ns / 1ps
// i2cms_checker: tracks the I2C master sequencer's transaction state from the input
// transfers, predicts each result and compares it with the result transfers.
// Depends on i2cms_pkg and the channel interfaces in i2cms_if.
module i2cms_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    i2cms_in_if     i_in,
    i2cms_out_if    i_out,
    output int      o_err_cnt,
    output int      o_pending
);
    import i2cms_pkg::*;

    localparam int SEND_DEPTH    = 4;
    localparam int RECEIVE_DEPTH = 5;
    localparam int MAX_REPORTS   = 10;

    logic [6:0] slave_addr;
    logic       rd_mode;
    logic [2:0] tx_count;
    logic [2:0] rx_count;
    logic [2:0] tx_idx;
    logic [2:0] rx_idx;
    logic [7:0] tx_buf [SEND_DEPTH];
    logic [7:0] rx_buf [RECEIVE_DEPTH];
    t_out_item  action_q [$];
    int         err_cnt;

    function automatic logic [7:0] pop_tx_byte();
        logic [7:0] b;
        b = (tx_idx < SEND_DEPTH) ? tx_buf[tx_idx] : 8'h00;
        tx_idx = tx_idx + 3'd1;
        return b;
    endfunction

    function automatic void push_rx_byte(input logic [7:0] b);
        if (rx_idx < RECEIVE_DEPTH) rx_buf[rx_idx] = b;
        rx_idx = rx_idx + 3'd1;
    endfunction

    // next control-register action for one input transfer; updates the tracked state
    function automatic t_out_item next_action(input t_in_item it);
        t_out_item r;
        r = '0;
        if (it.action == ACT_START) begin
            slave_addr = it.device_address;
            rd_mode    = it.mode;
            tx_count   = (it.send_count > SEND_DEPTH) ? 3'(SEND_DEPTH) : it.send_count;
            rx_count   = it.recv_count;
            for (int i = 0; i < SEND_DEPTH; i++) tx_buf[i] = it.write_data[31 - 8 * i -: 8];
            tx_idx = '0;
            rx_idx = '0;
            r.write_control = 1'b1;
            r.set_start     = 1'b1;
        end else if (!it.timeout) begin
            case (it.status_code)
                ST_START_SENT: begin
                    r.write_control = 1'b1;
                    r.load_data     = 1'b1;
                    r.data_byte     = {slave_addr, RW_WRITE};
                end
                ST_SLA_W_ACK: begin
                    r.write_control = 1'b1;
                    if (tx_count == 0) begin
                        r.set_start = 1'b1;
                    end else begin
                        r.load_data = 1'b1;
                        r.data_byte = pop_tx_byte();
                    end
                end
                ST_SLA_W_NACK, ST_DATA_TX_NACK: begin
                    r.write_control = 1'b1;
                    r.set_stop      = 1'b1;
                    r.done_res      = 1'b1;
                end
                ST_DATA_TX_ACK: begin
                    r.write_control = 1'b1;
                    if (tx_idx != tx_count) begin
                        r.load_data = 1'b1;
                        r.data_byte = pop_tx_byte();
                    end else if (rd_mode) begin
                        r.set_start = 1'b1;
                    end else begin
                        r.set_stop = 1'b1;
                        r.done_res = 1'b1;
                    end
                end
                ST_RESTART_SENT: begin
                    if (rd_mode) begin
                        r.write_control = 1'b1;
                        r.load_data     = 1'b1;
                        r.data_byte     = {slave_addr, RW_READ};
                    end else begin
                        r.done_res = 1'b1;
                    end
                end
                ST_SLA_R_ACK: begin
                    if (rd_mode) begin
                        r.write_control = 1'b1;
                        r.set_ack       = 1'b1;
                    end else begin
                        r.done_res = 1'b1;
                    end
                end
                ST_DATA_RX_ACK: begin
                    if (rd_mode) begin
                        r.write_control = 1'b1;
                        // count met: byte not kept, next one not acknowledged
                        if (rx_idx != rx_count) begin
                            push_rx_byte(it.rx_byte);
                            r.set_ack = 1'b1;
                        end
                    end else begin
                        r.done_res = 1'b1;
                    end
                end
                ST_DATA_RX_NACK: begin
                    if (rd_mode) begin
                        push_rx_byte(it.rx_byte);
                        r.write_control = 1'b1;
                        r.set_stop      = 1'b1;
                        r.done_res      = 1'b1;
                    end else begin
                        r.done_res = 1'b1;
                    end
                end
                default: begin
                    r.write_control = rd_mode;
                    r.set_stop      = rd_mode;
                    r.done_res      = 1'b1;
                end
            endcase
        end
        r.read_word = {rx_buf[0], rx_buf[1]};
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            slave_addr = '0;
            rd_mode    = 1'b0;
            tx_count   = '0;
            rx_count   = '0;
            tx_idx     = '0;
            rx_idx     = '0;
            foreach (tx_buf[i]) tx_buf[i] = '0;
            foreach (rx_buf[i]) rx_buf[i] = '0;
            action_q.delete();
            err_cnt = 0;
        end else begin
            if (i_in.valid && i_in.ready) action_q.push_back(next_action(i_in.payload));
            if (i_out.valid && i_out.ready) begin
                got = i_out.payload;
                if (action_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: result transfer with nothing pending: %h", $realtime, got);
                end else begin
                    want = action_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display({"%0t: mismatch: expected wc=%b sta=%b sto=%b aa=%b ",
                                      "ld=%b byte=%h done=%b word=%h, got wc=%b sta=%b ",
                                      "sto=%b aa=%b ld=%b byte=%h done=%b word=%h"},
                                     $realtime,
                                     want.write_control, want.set_start, want.set_stop,
                                     want.set_ack, want.load_data, want.data_byte,
                                     want.done_res, want.read_word,
                                     got.write_control, got.set_start, got.set_stop,
                                     got.set_ack, got.load_data, got.data_byte,
                                     got.done_res, got.read_word);
                    end
                end
            end
        end
        o_err_cnt <= err_cnt;
        o_pending <= action_q.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: drives directed and random I2C transactions into the master sequencer with
// random stalls on both channels and gives the verdict. Depends on i2cms_pkg,
// i2cms_if, the sequencer top level and i2cms_checker.
module tb_top;
    import i2cms_pkg::*;

    localparam logic [7:0] ST_BUS_ERROR = 8'h00;
    localparam logic [7:0] ST_NO_INFO   = 8'hF8;
    localparam logic [7:0] KNOWN_CODES [9] = '{ST_START_SENT, ST_RESTART_SENT, ST_SLA_W_ACK,
        ST_SLA_W_NACK, ST_DATA_TX_ACK, ST_DATA_TX_NACK, ST_SLA_R_ACK, ST_DATA_RX_ACK,
        ST_DATA_RX_NACK};
    localparam int RANDOM_ITEMS   = 500;
    localparam int PAUSE_EVERY    = 120;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   n_items;
    int   idle_cycles;
    int   err_cnt;
    int   pending;

    i2cms_in_if  in_ch ();
    i2cms_out_if out_ch ();

    i2c_master_transaction_sequencer_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    i2cms_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_err_cnt (err_cnt),
        .o_pending (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // result side: random stall before each transfer
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            @(negedge clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    function automatic t_in_item random_fill();
        return t_in_item'({$urandom, $urandom});
    endfunction

    task automatic put_item(input t_in_item it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic start_txn(input logic [6:0] addr, input logic md, input logic [2:0] sc,
                             input logic [31:0] data, input logic [2:0] rc);
        t_in_item it;
        it = random_fill();
        it.action         = ACT_START;
        it.device_address = addr;
        it.mode           = md;
        it.send_count     = sc;
        it.write_data     = data;
        it.recv_count     = rc;
        put_item(it);
        n_items++;
    endtask

    task automatic status(input logic [7:0] code, input logic [7:0] rx, input logic tmo);
        t_in_item it;
        it = random_fill();
        it.action      = !ACT_START;
        it.status_code = code;
        it.rx_byte     = rx;
        it.timeout     = tmo;
        put_item(it);
        if (!tmo) n_items++;
    endtask

    task automatic drain_pause();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic run_transaction();
        logic [7:0] codes [$];
        logic [7:0] fault;
        logic [2:0] sc;
        logic [2:0] rc;
        logic       md;
        int         n_tx;
        int         cut;
        md = 1'($urandom_range(0, 1));
        sc = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        rc = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        n_tx = (sc > 4) ? 4 : int'(sc);
        codes.push_back(ST_START_SENT);
        codes.push_back(ST_SLA_W_ACK);
        repeat (n_tx) codes.push_back(ST_DATA_TX_ACK);
        if (md) begin
            codes.push_back(ST_RESTART_SENT);
            codes.push_back(ST_SLA_R_ACK);
            repeat (rc) codes.push_back(ST_DATA_RX_ACK);
            if ($urandom_range(0, 3) == 0) codes.push_back(ST_DATA_RX_ACK);
            codes.push_back(ST_DATA_RX_NACK);
        end else if (n_tx == 0) begin
            codes.push_back(ST_SLA_W_NACK);
        end
        // broken transaction: possibly cut short, ending on a failure, no-info or random code
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, codes.size());
            while (codes.size() > cut) void'(codes.pop_back());
            case ($urandom_range(0, 4))
                0:       fault = ST_SLA_W_NACK;
                1:       fault = ST_DATA_TX_NACK;
                2:       fault = ST_DATA_RX_NACK;
                3:       fault = ST_NO_INFO;
                default: fault = 8'($urandom);
            endcase
            codes[codes.size() - 1] = fault;
        end
        quiet = ($urandom_range(0, 9) == 0);
        start_txn(7'($urandom), md, sc, $urandom, rc);
        foreach (codes[i]) begin
            if ($urandom_range(0, 9) == 0) status(8'($urandom), 8'($urandom), 1'b1);
            status(codes[i], 8'($urandom), 1'b0);
        end
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4))
                status(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                   : KNOWN_CODES[$urandom_range(0, 8)],
                       8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int goal;
        int next_pause;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        quiet          = 1'b0;
        n_items        = 0;
        idle_cycles    = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: unknown code before any start, full read with overflowing stores
        status(ST_BUS_ERROR, 8'h00, 1'b0);
        start_txn(7'h7F, 1'b1, 3'd7, 32'hFFFF_FFFF, 3'd7);
        status(ST_START_SENT, 8'h00, 1'b0);
        status(ST_SLA_W_ACK, 8'h00, 1'b0);
        repeat (4) status(ST_DATA_TX_ACK, 8'h00, 1'b0);
        status(ST_RESTART_SENT, 8'h00, 1'b0);
        status(ST_SLA_R_ACK, 8'h00, 1'b0);
        status(ST_DATA_RX_ACK, 8'hFF, 1'b0);
        status(ST_DATA_RX_NACK, 8'h12, 1'b1);
        status(ST_DATA_RX_ACK, 8'h00, 1'b0);
        status(ST_DATA_RX_NACK, 8'hA5, 1'b0);
        status(ST_DATA_RX_NACK, 8'h5A, 1'b0);
        status(ST_DATA_RX_NACK, 8'hC3, 1'b0);
        status(ST_DATA_RX_NACK, 8'h3C, 1'b0);
        // read count already met, then failure and unknown codes in read mode
        start_txn(7'h00, 1'b1, 3'd1, 32'h8000_0000, 3'd0);
        status(ST_DATA_RX_ACK, 8'h77, 1'b0);
        status(ST_DATA_TX_NACK, 8'h00, 1'b0);
        status(ST_NO_INFO, 8'h00, 1'b0);
        // write only with nothing to send
        start_txn(7'h00, 1'b0, 3'd0, 32'h0000_0000, 3'd0);
        status(ST_SLA_W_ACK, 8'h00, 1'b0);
        status(ST_SLA_W_NACK, 8'h00, 1'b0);
        status(ST_SLA_R_ACK, 8'h00, 1'b0);
        drain_pause();

        goal       = n_items + RANDOM_ITEMS;
        next_pause = n_items + PAUSE_EVERY;
        while (n_items < goal) begin
            run_transaction();
            if (n_items >= next_pause) begin
                drain_pause();
                next_pause = n_items + PAUSE_EVERY;
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
